// ===== rtl/slhm_pkg.sv =====
package slhm_pkg;

  // Widths of the fixed result counter fields and of the time base.
  localparam int COUNT_W = 32;
  localparam int TIME_W  = 32;

  // Command codes carried in the request.
  localparam logic [2:0] CMD_FRAME        = 3'd0;
  localparam logic [2:0] CMD_HEALTH_CHECK = 3'd1;
  localparam logic [2:0] CMD_USABLE_CHECK = 3'd2;
  localparam logic [2:0] CMD_TAKE_SAMPLE  = 3'd3;
  localparam logic [2:0] CMD_CSUM_REJECT  = 3'd4;
  localparam logic [2:0] CMD_LEN_REJECT   = 3'd5;

  // Configuration register indexes.
  localparam int          REG_COUNT = 7;
  localparam int          REG_IDX_W = $clog2(REG_COUNT);
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY_FRAMES  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_STALE_TIMEOUT    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_LOST_TIMEOUT     = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE     = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_MIN_QUALITY      = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RANGE_MESSAGE_ID = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_EXPECTED_LENGTH  = REG_IDX_W'(6);
  localparam int          CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] RST_RECOVERY_FRAMES  = 16'd3;
  localparam logic [15:0] RST_STALE_TIMEOUT    = 16'd100;
  localparam logic [15:0] RST_LOST_TIMEOUT     = 16'd500;
  localparam logic [15:0] RST_MIN_DISTANCE     = 16'd0;
  localparam logic [7:0]  RST_MIN_QUALITY      = 8'd0;
  localparam logic [7:0]  RST_RANGE_MESSAGE_ID = 8'd81;
  localparam logic [7:0]  RST_EXPECTED_LENGTH  = 8'd0;

  // Event counter slots.
  localparam int CNT_NUM   = 5;
  localparam int CNT_OK    = 0;
  localparam int CNT_GAP   = 1;
  localparam int CNT_CSUM  = 2;
  localparam int CNT_LEN   = 3;
  localparam int CNT_UNSUP = 4;

  typedef enum logic [1:0] {
    H_INIT  = 2'd0,
    H_VALID = 2'd1,
    H_STALE = 2'd2,
    H_LOST  = 2'd3
  } health_t;

  typedef struct packed {
    logic [15:0] recovery_frames;
    logic [15:0] stale_timeout;
    logic [15:0] lost_timeout;
    logic [15:0] min_distance;
    logic [7:0]  min_quality;
    logic [7:0]  range_message_id;
    logic [7:0]  expected_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] now_ms;
    logic [7:0]        msg_id;
    logic [7:0]        payload_len;
    logic [7:0]        seq;
    logic [15:0]       distance;
    logic [7:0]        optical_quality;
  } item_t;

  typedef struct packed {
    logic [1:0]         health;
    logic               usable;
    logic               sample_present;
    logic               frame_accepted;
    logic [7:0]         latest_seq;
    logic [15:0]        latest_distance;
    logic [7:0]         latest_quality;
    logic [COUNT_W-1:0] ok_count;
    logic [COUNT_W-1:0] gap_count;
    logic [COUNT_W-1:0] csum_reject_count;
    logic [COUNT_W-1:0] length_fail_count;
    logic [COUNT_W-1:0] unsupported_count;
  } result_t;

endpackage

// ===== rtl/slhm_item_if.sv =====
interface slhm_item_if;
  logic                valid;
  logic                ready;
  slhm_pkg::item_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/slhm_result_if.sv =====
interface slhm_result_if;
  logic                valid;
  logic                ready;
  slhm_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sensor_link_health_monitor.sv =====
// Sensor link health monitor.
// Requests arrive on the item channel (valid/ready, accepted when both are
// high): parsed frames, health checks, usable checks, sample reads and
// parser reject events. Each request yields exactly one result on the
// result channel, in request order, carrying the health state, the usable
// flag, the latest sample and the five event counters after that request.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle. The user must write them only while no request
// is in flight; the block itself does not enforce this. A request held in
// the input register has its result loaded into the result register once
// the result slot is free. Throughput is one request per cycle while the
// receiver takes results; the whole update is one pass of compare/subtract/
// increment logic between the input register and the result register.
// Reset (rst, synchronous) empties both registers, returns health to init,
// clears the sample, times and counters, and loads register defaults.
// When the receiver stalls the result is held; one more request is taken
// into the input register, after which ready drops until the result leaves.
module sensor_link_health_monitor #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [slhm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [slhm_pkg::CFG_DATA_W-1:0]  cfg_data,
  slhm_item_if.sink                        item,
  slhm_result_if.source                    result
);

  slhm_pkg::cfg_t     cfg;
  slhm_pkg::item_t    s1_item;
  logic               s1_valid;
  slhm_pkg::result_t  res_calc;
  slhm_pkg::result_t  out_data;
  logic               out_valid;
  logic               adv;

  // Register file.
  slhm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // State update and result computation.
  slhm_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (s1_item),
    .fire (adv),
    .res  (res_calc)
  );

  // Handshake: the held request moves on when the result slot is free.
  assign adv        = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) s1_item <= item.data;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res_calc;
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ===== rtl/slhm_cfg.sv =====
module slhm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slhm_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [slhm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output slhm_pkg::cfg_t                      cfg
);

  // Register file; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recovery_frames  <= slhm_pkg::RST_RECOVERY_FRAMES;
      cfg.stale_timeout    <= slhm_pkg::RST_STALE_TIMEOUT;
      cfg.lost_timeout     <= slhm_pkg::RST_LOST_TIMEOUT;
      cfg.min_distance     <= slhm_pkg::RST_MIN_DISTANCE;
      cfg.min_quality      <= slhm_pkg::RST_MIN_QUALITY;
      cfg.range_message_id <= slhm_pkg::RST_RANGE_MESSAGE_ID;
      cfg.expected_length  <= slhm_pkg::RST_EXPECTED_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slhm_pkg::REG_RECOVERY_FRAMES:  cfg.recovery_frames  <= cfg_data;
        slhm_pkg::REG_STALE_TIMEOUT:    cfg.stale_timeout    <= cfg_data;
        slhm_pkg::REG_LOST_TIMEOUT:     cfg.lost_timeout     <= cfg_data;
        slhm_pkg::REG_MIN_DISTANCE:     cfg.min_distance     <= cfg_data;
        slhm_pkg::REG_MIN_QUALITY:      cfg.min_quality      <= cfg_data[7:0];
        slhm_pkg::REG_RANGE_MESSAGE_ID: cfg.range_message_id <= cfg_data[7:0];
        slhm_pkg::REG_EXPECTED_LENGTH:  cfg.expected_length  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/slhm_engine.sv =====
module slhm_engine #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  slhm_pkg::cfg_t     cfg,
  input  slhm_pkg::item_t    item,
  input  logic               fire,
  output slhm_pkg::result_t  res
);

  localparam int CW = COUNTER_WIDTH;

  // Link state.
  slhm_pkg::health_t             health, health_next;
  logic [15:0]                   rc, rc_next;
  logic                          sample_seen, sample_seen_next;
  logic [slhm_pkg::TIME_W-1:0]   last_frame_time, last_frame_time_next;
  logic [slhm_pkg::TIME_W-1:0]   last_check_time, last_check_time_next;
  logic [7:0]                    sample_seq, sample_seq_next;
  logic [15:0]                   sample_distance, sample_distance_next;
  logic [7:0]                    sample_quality, sample_quality_next;
  logic [CW-1:0]                 cnt [slhm_pkg::CNT_NUM];
  logic [CW-1:0]                 cnt_next [slhm_pkg::CNT_NUM];

  // Check results shared by the health and usable commands.
  slhm_pkg::health_t             health_chk;
  logic [15:0]                   rc_chk;
  logic [slhm_pkg::TIME_W-1:0]   age;
  logic                          rc_met;
  logic [7:0]                    seq_diff;
  logic                          usable;
  logic                          accepted;

  assign age      = item.now_ms - last_frame_time;
  assign rc_met   = rc >= cfg.recovery_frames;
  assign seq_diff = item.seq - sample_seq;

  // Health transition taken on a check.
  always_comb begin
    health_chk = health;
    rc_chk     = rc;
    if (!sample_seen) begin
      health_chk = slhm_pkg::H_INIT;
    end else begin
      unique case (health)
        slhm_pkg::H_INIT: begin
          if (rc_met) begin
            health_chk = slhm_pkg::H_VALID;
            rc_chk     = '0;
          end
        end
        slhm_pkg::H_VALID: begin
          if (age >= slhm_pkg::TIME_W'(cfg.stale_timeout)) health_chk = slhm_pkg::H_STALE;
        end
        slhm_pkg::H_STALE: begin
          if (age >= slhm_pkg::TIME_W'(cfg.lost_timeout)) health_chk = slhm_pkg::H_LOST;
          else if (rc_met) health_chk = slhm_pkg::H_VALID;
        end
        slhm_pkg::H_LOST: begin
          if (rc_met) health_chk = slhm_pkg::H_VALID;
        end
      endcase
    end
  end

  // Per-command update of state and counters.
  always_comb begin
    health_next          = health;
    rc_next              = rc;
    sample_seen_next     = sample_seen;
    last_frame_time_next = last_frame_time;
    last_check_time_next = last_check_time;
    sample_seq_next      = sample_seq;
    sample_distance_next = sample_distance;
    sample_quality_next  = sample_quality;
    cnt_next             = cnt;
    usable               = 1'b0;
    accepted             = 1'b0;
    unique case (item.command)
      slhm_pkg::CMD_FRAME: begin
        if (item.msg_id != cfg.range_message_id) begin
          cnt_next[slhm_pkg::CNT_UNSUP] = cnt[slhm_pkg::CNT_UNSUP] + CW'(1);
          rc_next = '0;
        end else if (item.payload_len != cfg.expected_length) begin
          cnt_next[slhm_pkg::CNT_LEN] = cnt[slhm_pkg::CNT_LEN] + CW'(1);
          rc_next = '0;
        end else begin
          if (sample_seen && seq_diff > 8'd1) begin
            cnt_next[slhm_pkg::CNT_GAP] = cnt[slhm_pkg::CNT_GAP] + CW'(1);
          end
          cnt_next[slhm_pkg::CNT_OK] = cnt[slhm_pkg::CNT_OK] + CW'(1);
          sample_seq_next      = item.seq;
          sample_distance_next = item.distance;
          sample_quality_next  = item.optical_quality;
          sample_seen_next     = 1'b1;
          last_frame_time_next = last_check_time;
          if (rc != 16'hFFFF) rc_next = rc + 16'd1;
          accepted = 1'b1;
        end
      end
      slhm_pkg::CMD_HEALTH_CHECK: begin
        health_next          = health_chk;
        rc_next              = rc_chk;
        last_check_time_next = item.now_ms;
      end
      slhm_pkg::CMD_USABLE_CHECK: begin
        health_next          = health_chk;
        rc_next              = rc_chk;
        last_check_time_next = item.now_ms;
        usable = (health_chk == slhm_pkg::H_VALID) && sample_seen &&
                 (sample_distance >= cfg.min_distance) &&
                 (sample_quality >= cfg.min_quality);
      end
      slhm_pkg::CMD_TAKE_SAMPLE: begin
        if (sample_seen) last_check_time_next = item.now_ms;
      end
      slhm_pkg::CMD_CSUM_REJECT: begin
        cnt_next[slhm_pkg::CNT_CSUM] = cnt[slhm_pkg::CNT_CSUM] + CW'(1);
        rc_next = '0;
      end
      slhm_pkg::CMD_LEN_REJECT: begin
        cnt_next[slhm_pkg::CNT_LEN] = cnt[slhm_pkg::CNT_LEN] + CW'(1);
        rc_next = '0;
      end
      default: ;
    endcase
  end

  // Result reports the state after this request.
  always_comb begin
    res.health            = health_next;
    res.usable            = usable;
    res.sample_present    = sample_seen_next;
    res.frame_accepted    = accepted;
    res.latest_seq        = sample_seq_next;
    res.latest_distance   = sample_distance_next;
    res.latest_quality    = sample_quality_next;
    res.ok_count          = slhm_pkg::COUNT_W'(cnt_next[slhm_pkg::CNT_OK]);
    res.gap_count         = slhm_pkg::COUNT_W'(cnt_next[slhm_pkg::CNT_GAP]);
    res.csum_reject_count = slhm_pkg::COUNT_W'(cnt_next[slhm_pkg::CNT_CSUM]);
    res.length_fail_count = slhm_pkg::COUNT_W'(cnt_next[slhm_pkg::CNT_LEN]);
    res.unsupported_count = slhm_pkg::COUNT_W'(cnt_next[slhm_pkg::CNT_UNSUP]);
  end

  // State registers advance when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      health          <= slhm_pkg::H_INIT;
      rc              <= '0;
      sample_seen     <= 1'b0;
      last_frame_time <= '0;
      last_check_time <= '0;
      sample_seq      <= '0;
      sample_distance <= '0;
      sample_quality  <= '0;
      for (int i = 0; i < slhm_pkg::CNT_NUM; i++) cnt[i] <= '0;
    end else if (fire) begin
      health          <= health_next;
      rc              <= rc_next;
      sample_seen     <= sample_seen_next;
      last_frame_time <= last_frame_time_next;
      last_check_time <= last_check_time_next;
      sample_seq      <= sample_seq_next;
      sample_distance <= sample_distance_next;
      sample_quality  <= sample_quality_next;
      cnt             <= cnt_next;
    end
  end

  // Without a published sample the link can only be in init.
  a_init_without_sample: assert property (@(posedge clk) disable iff (rst)
    !sample_seen |-> health == slhm_pkg::H_INIT)
    else $error("health left init without a sample");

  // A published frame leaves a sample behind.
  a_accept_sets_sample: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_accepted |=> sample_seen)
    else $error("accepted frame did not set the sample flag");

  // A published frame bumps the good frame counter by exactly one.
  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_accepted |=>
      cnt[slhm_pkg::CNT_OK] == CW'($past(cnt[slhm_pkg::CNT_OK]) + 1'b1))
    else $error("good frame counter did not advance");

  // Usable flow is only reported on a valid link.
  a_usable_needs_valid: assert property (@(posedge clk) disable iff (rst)
    fire && res.usable |-> res.health == slhm_pkg::H_VALID && res.sample_present)
    else $error("usable reported on a link that is not valid");

endmodule

// ===== tb/health_monitor_checker.sv =====
module health_monitor_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [slhm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [slhm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  slhm_pkg::item_t                 req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  slhm_pkg::result_t               rsp,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register file and of the link state.
  slhm_pkg::cfg_t               regs;
  slhm_pkg::health_t            link_state;
  logic [15:0]                  recovery_run;
  logic                         sample_held;
  logic [slhm_pkg::TIME_W-1:0]  frame_stamp;
  logic [slhm_pkg::TIME_W-1:0]  check_stamp;
  logic [7:0]                   held_seq;
  logic [15:0]                  held_distance;
  logic [7:0]                   held_quality;
  logic [slhm_pkg::COUNT_W-1:0] tally [slhm_pkg::CNT_NUM];

  // Results predicted for accepted requests, oldest first.
  slhm_pkg::result_t            pending_reports [$];
  int                           error_total = 0;

  // Print one line per mismatch and count it.
  task automatic report_error(input string msg);
    error_total++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // The shadow registers and link state return to their power-up values.
  task automatic clear_link();
    regs.recovery_frames  = slhm_pkg::RST_RECOVERY_FRAMES;
    regs.stale_timeout    = slhm_pkg::RST_STALE_TIMEOUT;
    regs.lost_timeout     = slhm_pkg::RST_LOST_TIMEOUT;
    regs.min_distance     = slhm_pkg::RST_MIN_DISTANCE;
    regs.min_quality      = slhm_pkg::RST_MIN_QUALITY;
    regs.range_message_id = slhm_pkg::RST_RANGE_MESSAGE_ID;
    regs.expected_length  = slhm_pkg::RST_EXPECTED_LENGTH;
    link_state    = slhm_pkg::H_INIT;
    recovery_run  = '0;
    sample_held   = 1'b0;
    frame_stamp   = '0;
    check_stamp   = '0;
    held_seq      = '0;
    held_distance = '0;
    held_quality  = '0;
    foreach (tally[i]) tally[i] = '0;
  endtask

  task automatic load_register(input logic [slhm_pkg::REG_IDX_W-1:0] idx,
                               input logic [slhm_pkg::CFG_DATA_W-1:0] val);
    unique case (idx)
      slhm_pkg::REG_RECOVERY_FRAMES:  regs.recovery_frames  = val;
      slhm_pkg::REG_STALE_TIMEOUT:    regs.stale_timeout    = val;
      slhm_pkg::REG_LOST_TIMEOUT:     regs.lost_timeout     = val;
      slhm_pkg::REG_MIN_DISTANCE:     regs.min_distance     = val;
      slhm_pkg::REG_MIN_QUALITY:      regs.min_quality      = val[7:0];
      slhm_pkg::REG_RANGE_MESSAGE_ID: regs.range_message_id = val[7:0];
      slhm_pkg::REG_EXPECTED_LENGTH:  regs.expected_length  = val[7:0];
      default: ;
    endcase
  endtask

  // A rejected frame or a parser reject bumps its counter and restarts recovery.
  task automatic reject_frame(input int slot);
    tally[slot]  = tally[slot] + 1'b1;
    recovery_run = '0;
  endtask

  // The health machine only moves here. Age wraps modulo the time width.
  task automatic judge_health(input logic [slhm_pkg::TIME_W-1:0] now);
    logic [slhm_pkg::TIME_W-1:0] age;
    check_stamp = now;
    age = now - frame_stamp;
    if (!sample_held) begin
      link_state = slhm_pkg::H_INIT;
    end else begin
      unique case (link_state)
        slhm_pkg::H_INIT: begin
          if (recovery_run >= regs.recovery_frames) begin
            link_state   = slhm_pkg::H_VALID;
            recovery_run = '0;
          end
        end
        slhm_pkg::H_VALID: begin
          if (age >= regs.stale_timeout) link_state = slhm_pkg::H_STALE;
        end
        slhm_pkg::H_STALE: begin
          if (age >= regs.lost_timeout) begin
            link_state = slhm_pkg::H_LOST;
          end else if (recovery_run >= regs.recovery_frames) begin
            link_state = slhm_pkg::H_VALID;
          end
        end
        default: begin
          if (recovery_run >= regs.recovery_frames) link_state = slhm_pkg::H_VALID;
        end
      endcase
    end
  endtask

  // Apply one request to the shadow state and form the result it must produce.
  task automatic advance_link(input slhm_pkg::item_t r, output slhm_pkg::result_t res);
    logic [7:0] seq_step;
    logic       usable_now;
    logic       took_frame;
    usable_now = 1'b0;
    took_frame = 1'b0;
    unique case (r.command)
      slhm_pkg::CMD_FRAME: begin
        if (r.msg_id != regs.range_message_id) begin
          reject_frame(slhm_pkg::CNT_UNSUP);
        end else if (r.payload_len != regs.expected_length) begin
          reject_frame(slhm_pkg::CNT_LEN);
        end else begin
          seq_step = r.seq - held_seq;
          if (sample_held && seq_step > 8'd1) begin
            tally[slhm_pkg::CNT_GAP] = tally[slhm_pkg::CNT_GAP] + 1'b1;
          end
          held_seq      = r.seq;
          held_distance = r.distance;
          held_quality  = r.optical_quality;
          sample_held   = 1'b1;
          frame_stamp   = check_stamp;
          tally[slhm_pkg::CNT_OK] = tally[slhm_pkg::CNT_OK] + 1'b1;
          if (recovery_run != 16'hFFFF) recovery_run = recovery_run + 1'b1;
          took_frame = 1'b1;
        end
      end
      slhm_pkg::CMD_HEALTH_CHECK: judge_health(r.now_ms);
      slhm_pkg::CMD_USABLE_CHECK: begin
        judge_health(r.now_ms);
        usable_now = (link_state == slhm_pkg::H_VALID) && sample_held &&
                     (held_distance >= regs.min_distance) &&
                     (held_quality >= regs.min_quality);
      end
      slhm_pkg::CMD_TAKE_SAMPLE: begin
        if (sample_held) check_stamp = r.now_ms;
      end
      slhm_pkg::CMD_CSUM_REJECT: reject_frame(slhm_pkg::CNT_CSUM);
      slhm_pkg::CMD_LEN_REJECT:  reject_frame(slhm_pkg::CNT_LEN);
      default: ;
    endcase
    res.health            = link_state;
    res.usable            = usable_now;
    res.sample_present    = sample_held;
    res.frame_accepted    = took_frame;
    res.latest_seq        = held_seq;
    res.latest_distance   = held_distance;
    res.latest_quality    = held_quality;
    res.ok_count          = tally[slhm_pkg::CNT_OK];
    res.gap_count         = tally[slhm_pkg::CNT_GAP];
    res.csum_reject_count = tally[slhm_pkg::CNT_CSUM];
    res.length_fail_count = tally[slhm_pkg::CNT_LEN];
    res.unsupported_count = tally[slhm_pkg::CNT_UNSUP];
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    slhm_pkg::result_t want;
    if (rst) begin
      clear_link();
      pending_reports.delete();
    end else begin
      if (cfg_we) load_register(cfg_index, cfg_data);
      if (rsp_valid && rsp_ready) begin
        if (pending_reports.size() == 0) begin
          report_error("result arrived with no request waiting");
        end else begin
          want = pending_reports.pop_front();
          compare_field("health", 32'(rsp.health), 32'(want.health));
          compare_field("usable", 32'(rsp.usable), 32'(want.usable));
          compare_field("sample_present", 32'(rsp.sample_present),
                        32'(want.sample_present));
          compare_field("frame_accepted", 32'(rsp.frame_accepted),
                        32'(want.frame_accepted));
          compare_field("latest_seq", 32'(rsp.latest_seq), 32'(want.latest_seq));
          compare_field("latest_distance", 32'(rsp.latest_distance),
                        32'(want.latest_distance));
          compare_field("latest_quality", 32'(rsp.latest_quality),
                        32'(want.latest_quality));
          compare_field("ok_count", rsp.ok_count, want.ok_count);
          compare_field("gap_count", rsp.gap_count, want.gap_count);
          compare_field("csum_reject_count", rsp.csum_reject_count,
                        want.csum_reject_count);
          compare_field("length_fail_count", rsp.length_fail_count,
                        want.length_fail_count);
          compare_field("unsupported_count", rsp.unsupported_count,
                        want.unsupported_count);
        end
      end
      if (req_valid && req_ready) begin
        advance_link(req, want);
        pending_reports.push_back(want);
      end
    end
    mismatches  <= error_total;
    outstanding <= pending_reports.size();
  end

endmodule

// ===== tb/tb_sensor_link_health_monitor.sv =====
module tb_sensor_link_health_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block leaves unused.
  localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
  localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;

  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_REQUESTS = 260;
  localparam int BURST_FRAMES   = 200;
  localparam int STALL_CYCLES   = 120;
  localparam int CYCLE_LIMIT    = 40000;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [slhm_pkg::REG_IDX_W-1:0]  cfg_index;
  logic [slhm_pkg::CFG_DATA_W-1:0] cfg_data;

  slhm_item_if   item_ch ();
  slhm_result_if result_ch ();

  int             mismatches;
  int             outstanding;
  int             cycle_count = 0;
  int             sent_total = 0;
  int             settings_used = 0;
  bit             steady = 1'b0;
  bit             stall_request = 1'b0;
  slhm_pkg::cfg_t shadow;
  logic [31:0]    wall_ms = '0;
  logic [7:0]     next_seq = '0;

  sensor_link_health_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  health_monitor_checker link_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (item_ch.valid),
    .req_ready   (item_ch.ready),
    .req         (item_ch.data),
    .rsp_valid   (result_ch.valid),
    .rsp_ready   (result_ch.ready),
    .rsp         (result_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request) begin
        result_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end
      result_ch.ready <= steady || ($urandom_range(99) >= 21);
      @(posedge clk);
    end
  end

  function automatic slhm_pkg::item_t build_req(input logic [2:0] cmd,
                                                input logic [31:0] now,
                                                input logic [7:0] id,
                                                input logic [7:0] len,
                                                input logic [7:0] sq,
                                                input logic [15:0] range_mm,
                                                input logic [7:0] qual);
    slhm_pkg::item_t r;
    r.command         = cmd;
    r.now_ms          = now;
    r.msg_id          = id;
    r.payload_len     = len;
    r.seq             = sq;
    r.distance        = range_mm;
    r.optical_quality = qual;
    return r;
  endfunction

  // Mostly well-formed frames and time-ordered checks, with rejects and noise.
  function automatic slhm_pkg::item_t random_req();
    slhm_pkg::item_t r;
    int              pick;
    int              span;
    int              jump;
    r = build_req(slhm_pkg::CMD_FRAME, $urandom(), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 16'($urandom()), 8'($urandom()));
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.msg_id      = shadow.range_message_id;
      r.payload_len = shadow.expected_length;
      if ($urandom_range(9) < 8) r.seq = next_seq;
      next_seq = r.seq + 8'd1;
      // Half the frames sit right at the usable thresholds.
      if ($urandom_range(1) == 1) begin
        r.distance        = shadow.min_distance + 16'($urandom_range(4)) - 16'd2;
        r.optical_quality = shadow.min_quality + 8'($urandom_range(4)) - 8'd2;
      end
    end else if (pick < 48) begin
      r.msg_id = shadow.range_message_id ^ (8'd1 << $urandom_range(7));
    end else if (pick < 54) begin
      r.msg_id      = shadow.range_message_id;
      r.payload_len = shadow.expected_length ^ (8'd1 << $urandom_range(7));
    end else if (pick < 70) begin
      r.command = slhm_pkg::CMD_HEALTH_CHECK;
    end else if (pick < 84) begin
      r.command = slhm_pkg::CMD_USABLE_CHECK;
    end else if (pick < 92) begin
      r.command = slhm_pkg::CMD_TAKE_SAMPLE;
    end else if (pick < 95) begin
      r.command = slhm_pkg::CMD_CSUM_REJECT;
    end else if (pick < 98) begin
      r.command = slhm_pkg::CMD_LEN_REJECT;
    end else begin
      r.command = ($urandom_range(1) == 1) ? CMD_SPARE_HIGH : CMD_SPARE_LOW;
    end
    // Time moves forward in steps scaled to the timeouts, with rare wild jumps.
    if (r.command inside {slhm_pkg::CMD_HEALTH_CHECK, slhm_pkg::CMD_USABLE_CHECK,
                          slhm_pkg::CMD_TAKE_SAMPLE}) begin
      span = int'(shadow.stale_timeout) + int'(shadow.lost_timeout) + 4;
      jump = $urandom_range(99);
      if (jump < 60) begin
        wall_ms = wall_ms + 32'($urandom_range(span / 4));
      end else if (jump < 95) begin
        wall_ms = wall_ms + 32'($urandom_range(2 * span));
      end else begin
        wall_ms = $urandom();
      end
      r.now_ms = wall_ms;
    end
    return r;
  endfunction

  // Offer one request, with a random gap first unless steady is set, and wait until it is taken.
  task automatic send_req(input slhm_pkg::item_t r);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= r;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent_total++;
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain_link();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slhm_pkg::REG_IDX_W-1:0] idx,
                           input logic [slhm_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic apply_settings(input slhm_pkg::cfg_t c);
    drain_link();
    write_reg(slhm_pkg::REG_RECOVERY_FRAMES, c.recovery_frames);
    write_reg(slhm_pkg::REG_STALE_TIMEOUT, c.stale_timeout);
    write_reg(slhm_pkg::REG_LOST_TIMEOUT, c.lost_timeout);
    write_reg(slhm_pkg::REG_MIN_DISTANCE, c.min_distance);
    write_reg(slhm_pkg::REG_MIN_QUALITY, slhm_pkg::CFG_DATA_W'(c.min_quality));
    write_reg(slhm_pkg::REG_RANGE_MESSAGE_ID, slhm_pkg::CFG_DATA_W'(c.range_message_id));
    write_reg(slhm_pkg::REG_EXPECTED_LENGTH, slhm_pkg::CFG_DATA_W'(c.expected_length));
    cfg_we <= 1'b0;
    shadow = c;
    settings_used++;
  endtask

  initial begin
    slhm_pkg::cfg_t setting;
    logic [7:0]     id;
    logic [7:0]     len;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    shadow.recovery_frames  = slhm_pkg::RST_RECOVERY_FRAMES;
    shadow.stale_timeout    = slhm_pkg::RST_STALE_TIMEOUT;
    shadow.lost_timeout     = slhm_pkg::RST_LOST_TIMEOUT;
    shadow.min_distance     = slhm_pkg::RST_MIN_DISTANCE;
    shadow.min_quality      = slhm_pkg::RST_MIN_QUALITY;
    shadow.range_message_id = slhm_pkg::RST_RANGE_MESSAGE_ID;
    shadow.expected_length  = slhm_pkg::RST_EXPECTED_LENGTH;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the power-up register values.
    id  = shadow.range_message_id;
    len = shadow.expected_length;
    // Checks and a sample read before any sample exists.
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, 32'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_USABLE_CHECK, 32'd5, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_TAKE_SAMPLE, 32'd10, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    // Unused codes with every field at its maximum.
    send_req(build_req(CMD_SPARE_LOW, '1, '1, '1, '1, '1, '1));
    send_req(build_req(CMD_SPARE_HIGH, '1, '1, '1, '1, '1, '1));
    // Wrong message id, wrong length and both parser rejects.
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id + 8'd1, len, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len + 8'd1, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_CSUM_REJECT, 32'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_LEN_REJECT, 32'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    // First sample, then recovery from init into valid with a sequence gap.
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd0, 16'hFFFF, 8'hFF));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, 32'd20, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd1, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd5, 16'd1234, 8'd77));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, 32'd30, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_USABLE_CHECK, 32'd40, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    // Valid ages into stale, a frame with a wrapped sequence step, then lost.
    send_req(build_req(slhm_pkg::CMD_TAKE_SAMPLE, 32'd200, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, 32'd150, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd4, 16'd500, 8'd10));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, 32'd800, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_USABLE_CHECK, 32'd801, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    // Lost back to valid, then an age that wraps around the time base.
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd5, 16'd600, 8'd20));
    send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, id, len, 8'd6, 16'd700, 8'd30));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, '1, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_USABLE_CHECK, 32'h10, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    next_seq = 8'd7;

    // A long burst of good frames back to back with no idling on either side;
    // recovery from lost completes only in its second half.
    setting = '0;
    setting.recovery_frames  = 16'(BURST_FRAMES / 2);
    setting.range_message_id = 8'($urandom());
    setting.expected_length  = 8'($urandom());
    apply_settings(setting);
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, wall_ms, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, wall_ms, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    steady = 1'b1;
    for (int n = 0; n < BURST_FRAMES; n++) begin
      send_req(build_req(slhm_pkg::CMD_FRAME, 32'd0, shadow.range_message_id,
                         shadow.expected_length, next_seq, 16'($urandom()),
                         8'($urandom())));
      next_seq = next_seq + 8'd1;
      if (n == BURST_FRAMES / 2 + 4) begin
        send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, wall_ms, 8'd0, 8'd0, 8'd0,
                           16'd0, 8'd0));
      end
    end
    send_req(build_req(slhm_pkg::CMD_HEALTH_CHECK, wall_ms, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    send_req(build_req(slhm_pkg::CMD_USABLE_CHECK, wall_ms, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0));
    steady = 1'b0;

    // Random requests under several register settings, the corners first.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      unique case (phase)
        0: setting = '0;
        1: begin
          setting = '1;
          setting.recovery_frames = 16'd1;
        end
        default: begin
          setting.recovery_frames  = 16'($urandom_range(6));
          setting.stale_timeout    = 16'($urandom_range(1, 300));
          setting.lost_timeout     = 16'($urandom_range(1200));
          setting.min_distance     = 16'($urandom_range(4000));
          setting.min_quality      = 8'($urandom_range(200));
          setting.range_message_id = 8'($urandom());
          setting.expected_length  = 8'($urandom());
        end
      endcase
      apply_settings(setting);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // Hold off the receiver once while requests keep coming.
        if (phase == 3 && n == 100) stall_request = 1'b1;
        send_req(random_req());
      end
    end

    drain_link();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests under %0d register settings, incl. a %0d-frame burst.",
             sent_total, settings_used, BURST_FRAMES);
    $display("Mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
